@@ rtl/mip_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mobile identity parser package
// Shared payload types, result kinds and sizing constants.
// ----------------------------------------------------------------------------
package mip_pkg;

    localparam int MAX_DIGITS   = 15;
    localparam int DIGIT_CNT_W  = 5;
    localparam int TMSI_W       = 32;
    localparam int TMSI_OCTETS  = 4;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_TMSI  = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [2:0] TYPE_NO_IDENTITY = 3'd0;
    localparam logic [2:0] TYPE_TMSI        = 3'd4;

    typedef struct packed {
        logic [7:0] octet;
        logic       last_octet;
    } mip_in_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [2:0]        identity_type;
        logic [3:0]        digit;
        logic [TMSI_W-1:0] tmsi;
        logic              end_of_identity;
    } mip_out_t;

    // One queued command: a first result and an optional second digit.
    typedef struct packed {
        mip_out_t   first;
        logic       two;
        logic [3:0] digit2;
        logic       end2;
    } mip_cmd_t;

endpackage : mip_pkg
`default_nettype wire

@@ rtl/mip_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mobile identity parser front end
// Accepts octets, tracks the element phase and issues result commands.
// ----------------------------------------------------------------------------
module mip_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mip_pkg::mip_in_t  s_data,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output mip_pkg::mip_cmd_t      cmd_data
);
    import mip_pkg::*;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_DIGITS = 4'b0010,
        PH_TMSI   = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             type_reg, type_next;
    logic                   odd_reg, odd_next;
    logic [TMSI_W-1:0]      tmsi_reg, tmsi_next;
    logic [2:0]             octets_reg, octets_next;
    logic [DIGIT_CNT_W-1:0] digits_reg, digits_next;

    logic                   take;
    logic                   emit;
    mip_cmd_t               cmd;
    logic [3:0]             lo, hi;
    logic                   last;
    logic                   drop;
    logic [DIGIT_CNT_W:0]   digit_sum;

    assign s_ready   = cmd_ready;
    assign take      = s_valid && s_ready;
    assign cmd_valid = take && emit;
    assign cmd_data  = cmd;

    assign lo   = s_data.octet[3:0];
    assign hi   = s_data.octet[7:4];
    assign last = s_data.last_octet;
    assign drop = last && !odd_reg;
    assign digit_sum = {1'b0, digits_reg} + (drop ? (DIGIT_CNT_W+1)'(1) : (DIGIT_CNT_W+1)'(2));

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        odd_next    = odd_reg;
        tmsi_next   = tmsi_reg;
        octets_next = octets_reg;
        digits_next = digits_reg;
        emit        = 1'b0;
        cmd         = '0;
        case (phase_reg)
            PH_FIRST: begin
                type_next   = s_data.octet[2:0];
                odd_next    = s_data.octet[3];
                tmsi_next   = '0;
                octets_next = '0;
                digits_next = '0;
                emit        = 1'b1;
                cmd.first.end_of_identity = 1'b1;
                if (s_data.octet[2:0] == TYPE_NO_IDENTITY) begin
                    cmd.first.kind = KIND_NONE;
                    phase_next     = last ? PH_FIRST : PH_SKIP;
                end else if (s_data.octet[2:0] == TYPE_TMSI) begin
                    cmd.first.kind = KIND_ERROR;
                    emit           = last;
                    phase_next     = last ? PH_FIRST : PH_TMSI;
                end else if (last && !s_data.octet[3]) begin
                    cmd.first.kind = KIND_NONE;
                    phase_next     = PH_FIRST;
                end else begin
                    digits_next               = DIGIT_CNT_W'(1);
                    cmd.first.kind            = KIND_DIGIT;
                    cmd.first.digit           = hi;
                    cmd.first.end_of_identity = last;
                    phase_next                = last ? PH_FIRST : PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                emit = 1'b1;
                if (digit_sum > (DIGIT_CNT_W+1)'(MAX_DIGITS)) begin
                    cmd.first.kind            = KIND_ERROR;
                    cmd.first.end_of_identity = 1'b1;
                    phase_next                = last ? PH_FIRST : PH_SKIP;
                end else begin
                    digits_next               = digit_sum[DIGIT_CNT_W-1:0];
                    cmd.first.kind            = KIND_DIGIT;
                    cmd.first.digit           = lo;
                    cmd.first.end_of_identity = drop;
                    cmd.two                   = !drop;
                    cmd.digit2                = hi;
                    cmd.end2                  = last;
                    if (last) begin
                        phase_next = PH_FIRST;
                    end
                end
            end
            PH_TMSI: begin
                tmsi_next   = {tmsi_reg[TMSI_W-9:0], s_data.octet};
                octets_next = octets_reg + 3'd1;
                cmd.first.end_of_identity = 1'b1;
                if (octets_next >= 3'(TMSI_OCTETS)) begin
                    emit           = 1'b1;
                    cmd.first.kind = KIND_TMSI;
                    cmd.first.tmsi = tmsi_next;
                    phase_next     = last ? PH_FIRST : PH_SKIP;
                end else if (last) begin
                    emit           = 1'b1;
                    cmd.first.kind = KIND_ERROR;
                    phase_next     = PH_FIRST;
                end
            end
            PH_SKIP: begin
                if (last) begin
                    phase_next = PH_FIRST;
                end
            end
            default: begin
                phase_next = PH_FIRST;
            end
        endcase
        cmd.first.identity_type = type_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_FIRST;
            type_reg   <= '0;
            odd_reg    <= 1'b0;
            tmsi_reg   <= '0;
            octets_reg <= '0;
            digits_reg <= '0;
        end else if (take) begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            odd_reg    <= odd_next;
            tmsi_reg   <= tmsi_next;
            octets_reg <= octets_next;
            digits_reg <= digits_next;
        end
    end

endmodule : mip_front
`default_nettype wire

@@ rtl/mip_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mobile identity parser command queue
// Short queue that decouples the front end from the result back end.
// ----------------------------------------------------------------------------
module mip_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mip_pkg::mip_cmd_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mip_pkg::mip_cmd_t       out_data
);
    import mip_pkg::*;

    mip_cmd_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != QCNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule : mip_queue
`default_nettype wire

@@ rtl/mip_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mobile identity parser back end
// Expands queued commands into result transactions through an output register.
// ----------------------------------------------------------------------------
module mip_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire mip_pkg::mip_cmd_t  cmd_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mip_pkg::mip_out_t       m_data
);
    import mip_pkg::*;

    logic     m_valid_reg, m_valid_next;
    mip_out_t m_data_reg, m_data_next;
    logic     sel_reg, sel_next;
    logic     load;
    mip_out_t second;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign load    = !m_valid_reg || m_ready;

    always_comb begin
        second                 = '0;
        second.kind            = KIND_DIGIT;
        second.identity_type   = cmd_data.first.identity_type;
        second.digit           = cmd_data.digit2;
        second.end_of_identity = cmd_data.end2;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        sel_next     = sel_reg;
        cmd_ready    = 1'b0;
        if (load) begin
            m_valid_next = cmd_valid;
            if (cmd_valid) begin
                m_data_next = sel_reg ? second : cmd_data.first;
                // drop the command once its final result is loaded into the output register
                if (sel_reg || !cmd_data.two) begin
                    cmd_ready = 1'b1;
                    sel_next  = 1'b0;
                end else begin
                    sel_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
        end
    end

endmodule : mip_back
`default_nettype wire

@@ rtl/mobile_identity_parser_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mobile identity parser unit
// Decodes mobile identity element octets into digit, TMSI or status results.
// ----------------------------------------------------------------------------
// Octets enter on the s_ channel, one transaction each, with last_octet on
// the final one. The front end takes one octet per cycle whenever the
// two-entry command queue has room; it follows the element phase (first
// octet, digits, TMSI, skip to last) and posts one command for every octet
// that yields a result. The back end turns each command into one or two
// result transactions on the m_ channel through a single output register,
// so it issues one result per cycle unless m_ready stalls it: octets giving
// zero or one result sustain one octet per cycle, and a digit octet giving
// two results occupies the output register for both. A result passes through
// the queue and the output register. There are no configuration registers.
// ----------------------------------------------------------------------------
module mobile_identity_parser_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mip_pkg::mip_in_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mip_pkg::mip_out_t       m_data
);
    import mip_pkg::*;

    logic     fq_valid, fq_ready;
    mip_cmd_t fq_data;
    logic     qb_valid, qb_ready;
    mip_cmd_t qb_data;

    // Classify octets and advance the phase.
    mip_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd_data  (fq_data)
    );

    // Hold commands so that each side stalls on its own.
    mip_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    // Issue results, one transaction per cycle unless m_ready stalls the output.
    mip_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd_data  (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule : mobile_identity_parser_unit
`default_nettype wire
